[src/parity_framed_carrier_burst_transmitter_assert.svh]
// assertion macros for the carrier burst transmitter
`ifndef PARITY_FRAMED_CARRIER_BURST_TRANSMITTER_ASSERT_SVH
`define PARITY_FRAMED_CARRIER_BURST_TRANSMITTER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PFCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PFCBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PFCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PFCBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/pfcbt_pkg.sv]
package pfcbt_pkg;

    localparam int unsigned FRAME_SLOTS = 11;
    localparam int unsigned SLOT_W      = 4;

    localparam logic       OP_TICK = 1'b0;
    localparam logic       OP_LOAD = 1'b1;

    localparam logic       REG_HALF_PERIOD    = 1'b0;
    localparam logic       REG_PULSES_PER_BIT = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RST    = 8'd122;
    localparam logic [7:0] PULSES_PER_BIT_RST = 8'd16;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic coil;
        logic busy_res;
        logic rejected;
    } t_out;

endpackage

[src/parity_framed_carrier_burst_transmitter.sv]
// Carrier burst transmitter: each request is either a timer tick or a byte load, and each
// request yields exactly one result (coil level, busy, rejected), loaded into the output
// register the cycle after it is taken if the output is free, held back while it is stalled.
// A request is taken every clock while the skid register is empty; the frame state machine
// updates in one pass from the current state, and results go through an output register
// backed by a one-entry skid register, so o_in_ready depends only on whether it holds a result.
// A frame is 11 slots: a start slot that bursts, eight data bits LSB first and even parity
// (each bursting when the bit is 0), then a silent stop slot. A slot is pulses_per_bit
// carrier cycles of half_period ticks low followed by half_period ticks high on bursting slots.
// A load while busy is dropped and flagged rejected. Configuration writes take effect at once.
module parity_framed_carrier_burst_transmitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pfcbt_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pfcbt_pkg::t_out  o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    // configuration registers
    logic [7:0] r_half_period;
    logic [7:0] r_pulses_per_bit;

    // output register and skid register
    logic            r_out_valid;
    pfcbt_pkg::t_out r_out_data;
    logic            r_skid_valid;
    pfcbt_pkg::t_out r_skid_data;

    logic            in_accept;
    logic            out_free;
    pfcbt_pkg::t_out result;

    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    // output slot can load when empty or being drained this cycle
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period    <= pfcbt_pkg::HALF_PERIOD_RST;
            r_pulses_per_bit <= pfcbt_pkg::PULSES_PER_BIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfcbt_pkg::REG_HALF_PERIOD:    r_half_period    <= i_cfg_data;
                pfcbt_pkg::REG_PULSES_PER_BIT: r_pulses_per_bit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame state and per-request result
    pfcbt_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_item           (i_in_data),
        .i_half_period    (r_half_period),
        .i_pulses_per_bit (r_pulses_per_bit),
        .o_result         (result)
    );

    // control of the output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                // skid holds the older result, so it drains first
                r_out_valid  <= r_skid_valid || in_accept;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload of the output and skid registers
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end
        if (!out_free && in_accept) begin
            r_skid_data <= result;
        end
    end

`include "parity_framed_carrier_burst_transmitter_assert.svh"

    // skid register only fills behind a held output
    `PFCBT_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a refused load only happens mid-frame
    `PFCBT_ASSERT_IMP(a_rej_busy, i_clk, i_rst_n, r_out_valid && r_out_data.rejected, r_out_data.busy_res)
    // coil only drives while a frame is in progress
    `PFCBT_ASSERT_IMP(a_coil_busy, i_clk, i_rst_n, r_out_valid && r_out_data.coil, r_out_data.busy_res)
    // request taken against a stalled output lands in the skid register
    `PFCBT_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n, in_accept && r_out_valid && !i_out_ready, r_skid_valid)

endmodule

[src/pfcbt_core.sv]
module pfcbt_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  pfcbt_pkg::t_in   i_item,
    input  logic [7:0]       i_half_period,
    input  logic [7:0]       i_pulses_per_bit,
    output pfcbt_pkg::t_out  o_result
);

    logic [pfcbt_pkg::FRAME_SLOTS-1:0] r_flags, n_flags;
    logic [pfcbt_pkg::SLOT_W-1:0]      r_slot, n_slot, slot_inc;
    logic [7:0]                        r_pulse, n_pulse;
    logic [7:0]                        r_tick, n_tick;
    logic                              r_high, n_high;
    logic                              r_active, n_active;
    logic                              rej;
    logic [pfcbt_pkg::FRAME_SLOTS-1:0] flag_shift;

    always_comb begin
        n_flags  = r_flags;
        n_slot   = r_slot;
        n_pulse  = r_pulse;
        n_tick   = r_tick;
        n_high   = r_high;
        n_active = r_active;
        rej      = 1'b0;
        slot_inc = r_slot + 1'b1;
        if (i_accept) begin
            unique case (i_item.operation)
                pfcbt_pkg::OP_LOAD: begin
                    if (r_active) begin
                        rej = 1'b1;
                    end else begin
                        // start always bursts, data and parity burst on zero, stop silent
                        n_flags  = {1'b0, ~(^i_item.data_byte), ~i_item.data_byte, 1'b1};
                        n_slot   = '0;
                        n_pulse  = '0;
                        n_tick   = '0;
                        n_high   = 1'b0;
                        n_active = 1'b1;
                    end
                end
                default: begin
                    if (r_active) begin
                        if (({1'b0, r_tick} + 9'd1) >= {1'b0, i_half_period}) begin
                            n_tick = '0;
                            if (!r_high) begin
                                n_high = 1'b1;
                            end else begin
                                n_high = 1'b0;
                                if (({1'b0, r_pulse} + 9'd1) >= {1'b0, i_pulses_per_bit}) begin
                                    n_pulse = '0;
                                    n_slot  = slot_inc;
                                    if (slot_inc >= pfcbt_pkg::SLOT_W'(pfcbt_pkg::FRAME_SLOTS))
                                    begin
                                        n_slot   = '0;
                                        n_active = 1'b0;
                                    end
                                end else begin
                                    n_pulse = r_pulse + 8'd1;
                                end
                            end
                        end else begin
                            n_tick = r_tick + 8'd1;
                        end
                    end
                end
            endcase
        end
    end

    // result reflects the state after this item
    assign flag_shift        = n_flags >> n_slot;
    assign o_result.coil     = n_active & n_high & flag_shift[0]
                             & (n_slot < pfcbt_pkg::SLOT_W'(pfcbt_pkg::FRAME_SLOTS));
    assign o_result.busy_res = n_active;
    assign o_result.rejected = rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_slot   <= '0;
            r_pulse  <= '0;
            r_tick   <= '0;
            r_high   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_flags  <= n_flags;
            r_slot   <= n_slot;
            r_pulse  <= n_pulse;
            r_tick   <= n_tick;
            r_high   <= n_high;
            r_active <= n_active;
        end
    end

endmodule
